### hw/rtl/box_blur_3x3_clipped_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the 3x3 box blur block
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_CLIPPED_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_CLIPPED_TOP_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define BB3C_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define BB3C_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/bb3c_pkg.sv
// ---------------------------------------------------------------------------
// bb3c_pkg
// Types, constants and small tables shared by the 3x3 box blur modules.
// ---------------------------------------------------------------------------
`default_nettype none

package bb3c_pkg;

	localparam int CH_W        = 8;
	localparam int PIX_W       = 3 * CH_W;
	localparam int LINE_W      = 2 * PIX_W;
	localparam int CFG_W       = 11;
	localparam int CMP_W       = 15;
	localparam int SUM_W       = 12;
	localparam int VAL_W       = 13;
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 20;
	localparam int PROD_W      = VAL_W + RECIP_W;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_ISSUE,
		S_WAIT
	} state_t;

	// One average to work out: first window row and column taken, and flags.
	typedef struct packed {
		logic [1:0] rlo;
		logic [1:0] clo;
		logic       frame_last;
		logic       run_last;
	} avg_req_t;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
		logic            run_last;
		logic            frame_last;
	} result_t;

	function automatic logic [3:0] count_of(input logic [1:0] rlo, input logic [1:0] clo);
		logic [3:0] n;
		case ({rlo, clo})
			4'b0000: n = 4'd9;
			4'b0001: n = 4'd6;
			4'b0010: n = 4'd3;
			4'b0100: n = 4'd6;
			4'b0101: n = 4'd4;
			4'b0110: n = 4'd2;
			4'b1000: n = 4'd3;
			4'b1001: n = 4'd2;
			4'b1010: n = 4'd1;
			default: n = 4'd1;
		endcase
		return n;
	endfunction

	// ceil(2^20 / (2*count)); exact quotient for every dividend this block forms.
	function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] n);
		logic [RECIP_W-1:0] m;
		case (n)
			4'd1:    m = 20'd524288;
			4'd2:    m = 20'd262144;
			4'd3:    m = 20'd174763;
			4'd4:    m = 20'd131072;
			4'd6:    m = 20'd87382;
			4'd9:    m = 20'd58255;
			default: m = 20'd0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/box_blur_3x3_clipped_top.sv
// ---------------------------------------------------------------------------
// box_blur_3x3_clipped_top
// 3x3 box blur with clipped borders over a raster-order RGB pixel stream.
// ---------------------------------------------------------------------------
// Pixels enter on the s_ channel in raster order; results leave on the m_
// channel as soon as a pixel's neighbourhood is complete, in raster order
// except in the last row, whose results alternate with the row above.
// m_tlast marks the last result caused by an input item, m_tuser marks the
// bottom-right pixel's result. The user is to write frame_width and
// frame_height on the cfg port while the block is idle; the block itself
// does not enforce this. 0 acts as 1, values above the maximum act as the
// maximum. Each input item is accepted with a line store read, then the
// window is updated and the line store written; then, for each result it
// releases, an average is issued and passes the two-stage averaging unit,
// and each unused result slot is stepped over. One item is in work at a
// time. An input pixel releases zero, one, two or four results. The output
// register holds a result while m_tready is low; the block then stops
// issuing further averages but still takes the next input item once the
// current one has issued all its results. Reset clears the counters, the
// window and the output; line store contents are only used after being
// written in the same frame.
// ---------------------------------------------------------------------------
`default_nettype none
`include "box_blur_3x3_clipped_top_defines.svh"

module box_blur_3x3_clipped_top #(
	parameter int MAX_WIDTH  = bb3c_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bb3c_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_addr,
	input  wire logic [bb3c_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [bb3c_pkg::PIX_W-1:0]  s_tdata,  // in_red, in_green, in_blue
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [bb3c_pkg::PIX_W-1:0]       m_tdata,  // out_red, out_green, out_blue
	output logic                             m_tlast,  // run_last
	output logic                             m_tuser   // frame_last
);
	import bb3c_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);
	localparam logic [CMP_W-1:0] MAX_H_C = CMP_W'(MAX_HEIGHT);

	state_t                  state_q, state_d;
	logic [CFG_W-1:0]        cfg_w_q, cfg_h_q;
	logic [CW-1:0]           col_q;
	logic [RW-1:0]           row_q;
	logic [PIX_W-1:0]        px_q;
	logic [8:0][PIX_W-1:0]   win_q;
	logic [3:0]              slot_en_q;
	avg_req_t [3:0]          slot_req_q;
	logic [1:0]              slot_q;
	logic                    out_valid_q;
	result_t                 out_q;
	logic [LINE_W-1:0]       rd_data;
	logic                    s_acc;
	logic [CMP_W-1:0]        w_eff, h_eff, col_x, row_x;
	logic                    last_col, last_row, c_ge1, c_ge2, r_ge1, r_ge2;
	logic [1:0]              rlo_up, rlo_lo, clo0, clo1;
	logic                    more, issue, avg_valid;
	avg_req_t                req;
	result_t                 avg_res;

	// Effective frame size after clamping.
	always_comb begin
		w_eff = CMP_W'(cfg_w_q);
		if (cfg_w_q == '0) w_eff = CMP_W'(1);
		else if (CMP_W'(cfg_w_q) > MAX_W_C) w_eff = MAX_W_C;
		h_eff = CMP_W'(cfg_h_q);
		if (cfg_h_q == '0) h_eff = CMP_W'(1);
		else if (CMP_W'(cfg_h_q) > MAX_H_C) h_eff = MAX_H_C;
	end

	assign col_x    = CMP_W'(col_q);
	assign row_x    = CMP_W'(row_q);
	assign last_col = (col_x + CMP_W'(1)) >= w_eff;
	assign last_row = (row_x + CMP_W'(1)) >= h_eff;
	assign c_ge1    = col_x >= CMP_W'(1);
	assign c_ge2    = col_x >= CMP_W'(2);
	assign r_ge1    = row_x >= CMP_W'(1);
	assign r_ge2    = row_x >= CMP_W'(2);
	assign rlo_up   = r_ge2 ? 2'd0 : 2'd1;
	assign rlo_lo   = r_ge1 ? 2'd1 : 2'd2;
	assign clo0     = c_ge2 ? 2'd0 : 2'd1;
	assign clo1     = c_ge1 ? 2'd1 : 2'd2;

	assign s_acc = s_tvalid && s_tready;
	assign more  = |(slot_en_q & (4'b1110 << slot_q));

	always_comb begin
		req          = slot_req_q[slot_q];
		req.run_last = !more;
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		issue    = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = S_READ;
			end
			S_READ: begin
				state_d = ((c_ge1 || last_col) && (r_ge1 || last_row)) ? S_ISSUE : S_IDLE;
			end
			S_ISSUE: begin
				if (slot_en_q[slot_q]) begin
					if (!out_valid_q || m_tready) begin
						issue   = 1'b1;
						state_d = S_WAIT;
					end
				end else if (!more) begin
					state_d = S_IDLE;
				end
			end
			S_WAIT: begin
				if (avg_valid) state_d = more ? S_ISSUE : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= CFG_SIZE_RESET;
			cfg_h_q <= CFG_SIZE_RESET;
		end else if (cfg_we) begin
			if (cfg_addr == REG_FRAME_WIDTH) cfg_w_q <= cfg_data;
			if (cfg_addr == REG_FRAME_HEIGHT) cfg_h_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			win_q     <= '0;
			slot_en_q <= '0;
			slot_q    <= '0;
		end else begin
			case (state_q)
				S_READ: begin
					for (int i = 0; i < 3; i++) begin
						win_q[i*3+0] <= win_q[i*3+1];
						win_q[i*3+1] <= win_q[i*3+2];
					end
					win_q[2]  <= rd_data[LINE_W-1:PIX_W];
					win_q[5]  <= rd_data[PIX_W-1:0];
					win_q[8]  <= px_q;
					slot_en_q <= {last_col && last_row, last_col && r_ge1,
						c_ge1 && last_row, c_ge1 && r_ge1};
					slot_q    <= '0;
					if (last_col) begin
						col_q <= '0;
						row_q <= last_row ? '0 : RW'(row_x + CMP_W'(1));
					end else begin
						col_q <= CW'(col_x + CMP_W'(1));
					end
				end
				S_ISSUE: begin
					if (!slot_en_q[slot_q] && more) slot_q <= slot_q + 2'd1;
				end
				S_WAIT: begin
					if (avg_valid && more) slot_q <= slot_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) px_q <= s_tdata;
		if (state_q == S_READ) begin
			slot_req_q[0] <= '{rlo: rlo_up, clo: clo0, frame_last: 1'b0, run_last: 1'b0};
			slot_req_q[1] <= '{rlo: rlo_lo, clo: clo0, frame_last: 1'b0, run_last: 1'b0};
			slot_req_q[2] <= '{rlo: rlo_up, clo: clo1, frame_last: 1'b0, run_last: 1'b0};
			slot_req_q[3] <= '{rlo: rlo_lo, clo: clo1, frame_last: 1'b1, run_last: 1'b0};
		end
		if (avg_valid) out_q <= avg_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (avg_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	bb3c_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (s_acc),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (state_q == S_READ),
		.wr_addr (col_q),
		.wr_data ({rd_data[PIX_W-1:0], px_q})
	);

	bb3c_avg u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (issue),
		.req    (req),
		.win    (win_q),
		.valid  (avg_valid),
		.result (avg_res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.blue, out_q.green, out_q.red};
	assign m_tlast  = out_q.run_last;
	assign m_tuser  = out_q.frame_last;

	// An accepted item always goes on to the line store read cycle.
	`BB3C_ASSERT_NEXT(a_accept_read, s_tvalid && s_tready, state_q == S_READ, "item not read")
	// An average only completes when the output register is free.
	`BB3C_ASSERT(a_out_free, avg_valid |-> !out_valid_q, "output register overrun")
	// The frame's final result is always the last one of its item.
	`BB3C_ASSERT(a_frame_run, (m_tvalid && m_tuser) |-> m_tlast, "frame end not run end")
	// The line store read data is consumed only right after a read.
	`BB3C_ASSERT(a_read_src, (state_q == S_READ) |-> $past(s_tvalid && s_tready), "stray read")

endmodule

`default_nettype wire

### hw/rtl/bb3c_line_mem.sv
// ---------------------------------------------------------------------------
// bb3c_line_mem
// Line store: both previous rows of one column in one entry, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module bb3c_line_mem #(
	parameter int DEPTH = bb3c_pkg::MAX_WIDTH_DEF,
	parameter int AW    = 10
) (
	input  wire logic                      clk,
	input  wire logic                      rd_en,
	input  wire logic [AW-1:0]             rd_addr,
	output logic      [bb3c_pkg::LINE_W-1:0] rd_data,
	input  wire logic                      wr_en,
	input  wire logic [AW-1:0]             wr_addr,
	input  wire logic [bb3c_pkg::LINE_W-1:0] wr_data
);
	import bb3c_pkg::*;

	logic [LINE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/bb3c_avg.sv
// ---------------------------------------------------------------------------
// bb3c_avg
// Two-stage averaging unit: window sum, then multiply by reciprocal.
// ---------------------------------------------------------------------------
`default_nettype none

module bb3c_avg (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire bb3c_pkg::avg_req_t                     req,
	input  wire logic [8:0][bb3c_pkg::PIX_W-1:0]        win,
	output logic                                        valid,
	output bb3c_pkg::result_t                           result
);
	import bb3c_pkg::*;

	logic [2:0][VAL_W-1:0]  val_d;
	logic [3:0]             cnt_d;
	logic [2:0][VAL_W-1:0]  val_s1;
	logic [RECIP_W-1:0]     m_s1;
	logic [1:0]             flags_s1;
	logic                   vld_s1;
	logic [2:0][PROD_W-1:0] prod_s2;
	logic [1:0]             flags_s2;
	logic                   vld_s2;

	always_comb begin
		logic [SUM_W-1:0] s;
		cnt_d = count_of(req.rlo, req.clo);
		for (int ch = 0; ch < 3; ch++) begin
			s = '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (2'(i) >= req.rlo && 2'(j) >= req.clo) begin
						s = s + SUM_W'(win[i*3+j][ch*CH_W +: CH_W]);
					end
				end
			end
			// 2*sum + count, to be divided by 2*count.
			val_d[ch] = {s, 1'b0} + VAL_W'(cnt_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		val_s1   <= val_d;
		m_s1     <= recip_of(cnt_d);
		flags_s1 <= {req.frame_last, req.run_last};
		for (int ch = 0; ch < 3; ch++) begin
			prod_s2[ch] <= PROD_W'(val_s1[ch]) * PROD_W'(m_s1);
		end
		flags_s2 <= flags_s1;
	end

	assign valid             = vld_s2;
	assign result.red        = prod_s2[0][RECIP_SHIFT +: CH_W];
	assign result.green      = prod_s2[1][RECIP_SHIFT +: CH_W];
	assign result.blue       = prod_s2[2][RECIP_SHIFT +: CH_W];
	assign result.run_last   = flags_s2[0];
	assign result.frame_last = flags_s2[1];

endmodule

`default_nettype wire
